// ===== rtl/tcc_pkg.sv =====
// Shared types, codes and constants of the two-player countdown clock.
// No dependencies; imported by the channel interfaces and the top level.
package tcc_pkg;

    localparam int MinWidth     = 7;
    localparam int SecWidth     = 6;
    localparam int CfgDataWidth = 7;
    localparam int CfgIdxWidth  = 2;

    typedef logic [MinWidth-1:0]     minutes_t;
    typedef logic [SecWidth-1:0]     seconds_t;
    typedef logic [CfgDataWidth-1:0] cfg_data_t;

    localparam minutes_t MaxMinutes = 7'd99;
    localparam seconds_t MaxSeconds = 6'd59;
    localparam logic [SecWidth:0] SecPerMin = 7'd60;

    localparam minutes_t RstStartMinutes = 7'd5;
    localparam seconds_t RstStartSeconds = 6'd0;
    localparam seconds_t RstBonusSeconds = 6'd0;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SWITCH = 2'd1,
        CMD_PAUSE  = 2'd2,
        CMD_INIT   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RUN   = 2'd1,
        PH_PAUSE = 2'd2,
        PH_END   = 2'd3
    } phase_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_START_MIN = 2'd0,
        CFG_START_SEC = 2'd1,
        CFG_BONUS_SEC = 2'd2
    } cfg_index_t;

endpackage

// ===== rtl/tcc_in_if.sv =====
// Input channel of the countdown clock: valid/ready plus command word.
// Depends on tcc_pkg.
interface tcc_in_if;
    import tcc_pkg::*;

    logic valid;
    logic ready;
    cmd_t cmd;
    logic side_switch;

    modport source (output valid, output cmd, output side_switch, input ready);
    modport sink   (input valid, input cmd, input side_switch, output ready);
endinterface

// ===== rtl/tcc_out_if.sv =====
// Result channel of the countdown clock: valid/ready plus display word.
// Depends on tcc_pkg.
interface tcc_out_if;
    import tcc_pkg::*;

    logic     valid;
    logic     ready;
    logic     which_display;
    minutes_t show_minutes;
    seconds_t show_seconds;
    logic     colon_on;
    phase_t   game_phase;
    logic     phase_restart;
    logic     last_of_run;

    modport source (output valid, output which_display, output show_minutes,
                    output show_seconds, output colon_on, output game_phase,
                    output phase_restart, output last_of_run, input ready);
    modport sink   (input valid, input which_display, input show_minutes,
                    input show_seconds, input colon_on, input game_phase,
                    input phase_restart, input last_of_run, output ready);
endinterface

// ===== rtl/two_player_countdown_clock_unit.sv =====
// Top level of the two-player countdown clock with switch bonus.
// Depends on tcc_pkg, tcc_in_if and tcc_out_if.
//
//   channel   direction  handshake      word
//   in_ch     sink       valid/ready    cmd, side_switch
//   out_ch    source     valid/ready    display, time, colon, phase, flags
//   cfg       sink       cfg_write_en   cfg_index, cfg_data
//
// Tick, switch and pause words retire when they fire from the item register;
// init fires once per display result, as the single result register holds one.
// A new word is taken in the cycle the held one retires.
// Reset clears game state, config to its defaults and both registers' valid.
// A stalled result holds the item register; words with no result still pass.
module two_player_countdown_clock_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [tcc_pkg::CfgIdxWidth-1:0] cfg_index,
    input  tcc_pkg::cfg_data_t              cfg_data,
    tcc_in_if.sink                          in_ch,
    tcc_out_if.source                       out_ch
);
    import tcc_pkg::*;

    minutes_t start_min_reg;
    seconds_t start_sec_reg;
    seconds_t bonus_sec_reg;

    phase_t   phase_reg, phase_next;
    logic     active_reg, active_next;
    minutes_t clk_min_reg [2];
    minutes_t clk_min_next [2];
    seconds_t clk_sec_reg [2];
    seconds_t clk_sec_next [2];

    logic     item_valid_reg, item_valid_next;
    logic     half_reg, half_next;
    cmd_t     item_cmd_reg;
    logic     item_side_reg;

    logic     out_valid_reg, out_valid_next;
    logic     res_who_reg;
    minutes_t res_min_reg;
    seconds_t res_sec_reg;
    logic     res_colon_reg;
    phase_t   res_phase_reg;
    logic     res_restart_reg;
    logic     res_last_reg;

    minutes_t sm_sat;
    seconds_t ss_sat;
    seconds_t bonus_sat;
    minutes_t cur_m;
    seconds_t cur_s;
    minutes_t new_m;
    seconds_t new_s;
    logic [SecWidth:0] sum_s;

    logic     has_result;
    logic     item_done;
    logic     res_who;
    minutes_t res_min;
    seconds_t res_sec;
    logic     res_colon;
    logic     res_restart;
    logic     res_last;

    logic     in_accept;
    logic     out_free;
    logic     fire;
    logic     retire;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_min_reg <= RstStartMinutes;
            start_sec_reg <= RstStartSeconds;
            bonus_sec_reg <= RstBonusSeconds;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_START_MIN: start_min_reg <= cfg_data;
                CFG_START_SEC: start_sec_reg <= cfg_data[SecWidth-1:0];
                CFG_BONUS_SEC: bonus_sec_reg <= cfg_data[SecWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        sm_sat    = (start_min_reg > MaxMinutes) ? MaxMinutes : start_min_reg;
        ss_sat    = (start_sec_reg > MaxSeconds) ? MaxSeconds : start_sec_reg;
        bonus_sat = (bonus_sec_reg > MaxSeconds) ? MaxSeconds : bonus_sec_reg;

        cur_m = clk_min_reg[active_reg];
        cur_s = clk_sec_reg[active_reg];
        new_m = cur_m;
        new_s = cur_s;
        sum_s = {1'b0, cur_s} + {1'b0, bonus_sat};

        phase_next      = phase_reg;
        active_next     = active_reg;
        clk_min_next[0] = clk_min_reg[0];
        clk_min_next[1] = clk_min_reg[1];
        clk_sec_next[0] = clk_sec_reg[0];
        clk_sec_next[1] = clk_sec_reg[1];

        has_result  = 1'b0;
        item_done   = 1'b1;
        res_who     = active_reg;
        res_min     = cur_m;
        res_sec     = cur_s;
        res_colon   = 1'b1;
        res_restart = 1'b0;
        res_last    = 1'b1;

        unique case (item_cmd_reg)
            CMD_INIT:
            begin
                has_result = 1'b1;
                if (!half_reg)
                begin
                    phase_next      = PH_IDLE;
                    clk_min_next[0] = sm_sat;
                    clk_min_next[1] = sm_sat;
                    clk_sec_next[0] = ss_sat;
                    clk_sec_next[1] = ss_sat;
                    active_next     = ~item_side_reg;
                    item_done       = 1'b0;
                    res_who         = 1'b0;
                    res_min         = sm_sat;
                    res_sec         = ss_sat;
                    res_last        = 1'b0;
                end
                else
                begin
                    res_who = 1'b1;
                    res_min = clk_min_reg[1];
                    res_sec = clk_sec_reg[1];
                end
            end
            CMD_TICK:
            begin
                if (phase_reg == PH_RUN)
                begin
                    has_result = 1'b1;
                    if (cur_s == '0)
                    begin
                        if (cur_m == '0)
                        begin
                            phase_next = PH_END;
                        end
                        else
                        begin
                            new_s = MaxSeconds;
                            new_m = cur_m - 7'd1;
                        end
                    end
                    else
                    begin
                        new_s = cur_s - 6'd1;
                    end
                    clk_min_next[active_reg] = new_m;
                    clk_sec_next[active_reg] = new_s;
                    res_min   = new_m;
                    res_sec   = new_s;
                    res_colon = ~new_s[0];
                end
            end
            CMD_SWITCH:
            begin
                if (phase_reg == PH_IDLE || phase_reg == PH_RUN)
                begin
                    phase_next = PH_RUN;
                    has_result = 1'b1;
                    // carry the bonus into minutes, then cap at the start time
                    if (sum_s >= SecPerMin)
                    begin
                        new_s = SecWidth'(sum_s - SecPerMin);
                        new_m = cur_m + 7'd1;
                    end
                    else
                    begin
                        new_s = sum_s[SecWidth-1:0];
                    end
                    if ({new_m, new_s} > {sm_sat, ss_sat})
                    begin
                        new_m = sm_sat;
                        new_s = ss_sat;
                    end
                    clk_min_next[active_reg] = new_m;
                    clk_sec_next[active_reg] = new_s;
                    active_next = ~active_reg;
                    res_min     = new_m;
                    res_sec     = new_s;
                    res_restart = 1'b1;
                end
            end
            CMD_PAUSE:
            begin
                if (phase_reg == PH_RUN)
                begin
                    phase_next = PH_PAUSE;
                end
                else if (phase_reg == PH_PAUSE)
                begin
                    phase_next = PH_RUN;
                end
            end
            default: ;
        endcase
    end

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign fire      = item_valid_reg && (!has_result || out_free);
    assign retire    = fire && item_done;
    assign in_ch.ready = !item_valid_reg || retire;
    assign in_accept = in_ch.valid && in_ch.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (retire)
        begin
            item_valid_next = 1'b0;
        end

        half_next = half_reg;
        if (retire)
        begin
            half_next = 1'b0;
        end
        else if (fire)
        begin
            half_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (fire && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            half_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_IDLE;
            active_reg     <= 1'b0;
            clk_min_reg[0] <= '0;
            clk_min_reg[1] <= '0;
            clk_sec_reg[0] <= '0;
            clk_sec_reg[1] <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            half_reg       <= half_next;
            out_valid_reg  <= out_valid_next;
            if (fire)
            begin
                phase_reg      <= phase_next;
                active_reg     <= active_next;
                clk_min_reg[0] <= clk_min_next[0];
                clk_min_reg[1] <= clk_min_next[1];
                clk_sec_reg[0] <= clk_sec_next[0];
                clk_sec_reg[1] <= clk_sec_next[1];
            end
        end
    end

    // item and result words
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_cmd_reg  <= in_ch.cmd;
            item_side_reg <= in_ch.side_switch;
        end
        if (fire && has_result)
        begin
            res_who_reg     <= res_who;
            res_min_reg     <= res_min;
            res_sec_reg     <= res_sec;
            res_colon_reg   <= res_colon;
            res_phase_reg   <= phase_next;
            res_restart_reg <= res_restart;
            res_last_reg    <= res_last;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.which_display = res_who_reg;
    assign out_ch.show_minutes  = res_min_reg;
    assign out_ch.show_seconds  = res_sec_reg;
    assign out_ch.colon_on      = res_colon_reg;
    assign out_ch.game_phase    = res_phase_reg;
    assign out_ch.phase_restart = res_restart_reg;
    assign out_ch.last_of_run   = res_last_reg;

    a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
        clk_min_reg[0] <= MaxMinutes && clk_min_reg[1] <= MaxMinutes &&
        clk_sec_reg[0] <= MaxSeconds && clk_sec_reg[1] <= MaxSeconds)
        else $error("clock value out of range");

    a_half_is_init: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> item_valid_reg && item_cmd_reg == CMD_INIT)
        else $error("second init half without init word");

    a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_last_reg |->
            !res_who_reg && res_phase_reg == PH_IDLE && !res_restart_reg)
        else $error("non-final result other than first init display");

    a_end_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_END && !(fire && item_cmd_reg == CMD_INIT)
            |=> phase_reg == PH_END)
        else $error("ended game left end without init");

    a_switch_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && has_result && item_cmd_reg == CMD_SWITCH
            |=> out_valid_reg && res_restart_reg && res_phase_reg == PH_RUN)
        else $error("switch result without restart or run phase");

endmodule

// ===== tb/tcc_display_check.sv =====
// Scoreboard for the two-player countdown clock: tracks config writes, predicts the
// display words each command word causes, and compares them with the result channel.
// Depends on tcc_pkg, tcc_in_if and tcc_out_if.
`timescale 1ns / 100ps

module tcc_display_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [tcc_pkg::CfgIdxWidth-1:0] cfg_index,
    input  tcc_pkg::cfg_data_t              cfg_data,
    tcc_in_if                               in_w,
    tcc_out_if                              out_w,
    output int                              fail_count,
    output int                              pending
);
    import tcc_pkg::*;

    typedef struct packed {
        logic     which;
        minutes_t minutes;
        seconds_t seconds;
        logic     colon;
        phase_t   phase;
        logic     restart;
        logic     last;
    } display_word_t;

    minutes_t      start_min;
    seconds_t      start_sec;
    seconds_t      bonus;
    phase_t        game;
    logic          player;
    minutes_t      mins [2];
    seconds_t      secs [2];
    display_word_t display_q [$];
    display_word_t want;
    int            mismatches = 0;

    assign fail_count = mismatches;

    function automatic minutes_t limit_minutes();
        return (start_min > MaxMinutes) ? MaxMinutes : start_min;
    endfunction

    function automatic seconds_t limit_seconds();
        return (start_sec > MaxSeconds) ? MaxSeconds : start_sec;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [6:0] got,
                                 input logic [6:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, exp_val));
    endtask

    task automatic push_display(input logic who, input logic colon, input logic restart,
                                input logic last);
        display_word_t w;
        w.which   = who;
        w.minutes = mins[who];
        w.seconds = secs[who];
        w.colon   = colon;
        w.phase   = game;
        w.restart = restart;
        w.last    = last;
        display_q.push_back(w);
    endtask

    task automatic play_word(input cmd_t cmd, input logic side);
        int   total;
        int   limit;
        int   bonus_eff;
        logic p;
        p = player;
        case (cmd)
            CMD_INIT:
            begin
                game    = PH_IDLE;
                mins[0] = limit_minutes();
                mins[1] = limit_minutes();
                secs[0] = limit_seconds();
                secs[1] = limit_seconds();
                player  = ~side;
                push_display(1'b0, 1'b1, 1'b0, 1'b0);
                push_display(1'b1, 1'b1, 1'b0, 1'b1);
            end
            CMD_TICK:
            begin
                if (game == PH_RUN)
                begin
                    if (secs[p] == '0)
                    begin
                        if (mins[p] == '0)
                            game = PH_END;
                        else
                        begin
                            secs[p] = MaxSeconds;
                            mins[p] = mins[p] - 1'b1;
                        end
                    end
                    else
                        secs[p] = secs[p] - 1'b1;
                    push_display(p, ~secs[p][0], 1'b0, 1'b1);
                end
            end
            CMD_SWITCH:
            begin
                if (game == PH_IDLE)
                    game = PH_RUN;
                if (game == PH_RUN)
                begin
                    bonus_eff = (bonus > MaxSeconds) ? int'(MaxSeconds) : int'(bonus);
                    total = int'(mins[p]) * int'(SecPerMin) + int'(secs[p]) + bonus_eff;
                    limit = int'(limit_minutes()) * int'(SecPerMin) + int'(limit_seconds());
                    if (total > limit)
                        total = limit;
                    mins[p] = minutes_t'(total / int'(SecPerMin));
                    secs[p] = seconds_t'(total % int'(SecPerMin));
                    push_display(p, 1'b1, 1'b1, 1'b1);
                    player = ~p;
                end
            end
            CMD_PAUSE:
            begin
                if (game == PH_RUN)
                    game = PH_PAUSE;
                else if (game == PH_PAUSE)
                    game = PH_RUN;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_min = RstStartMinutes;
            start_sec = RstStartSeconds;
            bonus     = RstBonusSeconds;
            game      = PH_IDLE;
            player    = 1'b0;
            mins[0]   = '0;
            mins[1]   = '0;
            secs[0]   = '0;
            secs[1]   = '0;
            display_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_START_MIN: start_min = cfg_data;
                    CFG_START_SEC: start_sec = cfg_data[SecWidth-1:0];
                    CFG_BONUS_SEC: bonus = cfg_data[SecWidth-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_w.valid && out_w.ready)
            begin
                if (display_q.size() == 0)
                    report_mismatch("display word with none expected");
                else
                begin
                    want = display_q.pop_front();
                    compare_field("which_display", out_w.which_display, want.which);
                    compare_field("show_minutes", out_w.show_minutes, want.minutes);
                    compare_field("show_seconds", out_w.show_seconds, want.seconds);
                    compare_field("colon_on", out_w.colon_on, want.colon);
                    compare_field("game_phase", out_w.game_phase, want.phase);
                    compare_field("phase_restart", out_w.phase_restart, want.restart);
                    compare_field("last_of_run", out_w.last_of_run, want.last);
                end
            end
            if (in_w.valid && in_w.ready)
                play_word(in_w.cmd, in_w.side_switch);
            pending <= display_q.size();
        end
    end

endmodule

// ===== tb/two_player_countdown_clock_unit_test.sv =====
// Test top for the two-player countdown clock: drives command words and config
// writes under varying idle patterns, and gives the verdict from tcc_display_check.
// Depends on tcc_pkg, tcc_in_if, tcc_out_if and two_player_countdown_clock_unit.
`timescale 1ns / 100ps

module two_player_countdown_clock_unit_test;
    import tcc_pkg::*;

    localparam int QuietLimit    = 2000;
    localparam int SettleCycles  = 8;
    localparam int WordsPerPhase = 230;
    localparam int RandomPhases  = 6;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CfgIdxWidth-1:0] cfg_index;
    cfg_data_t              cfg_data;
    int                     gap_pct = 0;
    int                     stall_pct = 0;
    int                     quiet = 0;
    int                     fail_count;
    int                     pending;

    tcc_in_if  in_ch ();
    tcc_out_if out_ch ();

    two_player_countdown_clock_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch)
    );

    tcc_display_check display_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_w         (in_ch),
        .out_w        (out_ch),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QuietLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic cmd_t pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return CMD_TICK;
        else if (r < 88)
            return CMD_SWITCH;
        else if (r < 95)
            return CMD_PAUSE;
        return CMD_INIT;
    endfunction

    task automatic send_word(input cmd_t cmd, input logic side);
        while ($urandom_range(99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.side_switch <= side;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // hold off until every expected display word is in, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic load_config(input cfg_data_t minutes, input cfg_data_t seconds,
                               input cfg_data_t bonus);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_START_MIN;
        cfg_data     <= minutes;
        @(posedge clk);
        cfg_index    <= CFG_START_SEC;
        cfg_data     <= seconds;
        @(posedge clk);
        cfg_index    <= CFG_BONUS_SEC;
        cfg_data     <= bonus;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin
        cfg_data_t start_min;
        cfg_data_t start_sec;
        cfg_data_t bonus;
        rst_n             = 1'b0;
        cfg_write_en      = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_TICK;
        in_ch.side_switch = 1'b0;
        out_ch.ready      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        load_config(7'd0, 7'd3, 7'd2);
        send_word(CMD_TICK, 1'b0);
        send_word(CMD_PAUSE, 1'b1);
        send_word(CMD_SWITCH, 1'b0);
        send_word(CMD_INIT, 1'b1);
        send_word(CMD_SWITCH, 1'b0);
        repeat (4) send_word(CMD_TICK, 1'b1);
        send_word(CMD_TICK, 1'b0);
        send_word(CMD_SWITCH, 1'b1);
        send_word(CMD_PAUSE, 1'b0);
        send_word(CMD_INIT, 1'b0);
        send_word(CMD_SWITCH, 1'b1);
        send_word(CMD_PAUSE, 1'b0);
        send_word(CMD_TICK, 1'b1);
        send_word(CMD_SWITCH, 1'b0);
        send_word(CMD_PAUSE, 1'b1);
        send_word(CMD_TICK, 1'b0);
        drain();
        load_config(7'd127, 7'd63, 7'd63);
        send_word(CMD_INIT, 1'b1);
        send_word(CMD_SWITCH, 1'b0);
        send_word(CMD_TICK, 1'b1);
        send_word(CMD_SWITCH, 1'b0);
        repeat (2) send_word(CMD_TICK, 1'b0);

        for (int k = 0; k < RandomPhases; k++)
        begin
            drain();
            case (k % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 86; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 86; end
                default: begin gap_pct = 32; stall_pct = 32; end
            endcase
            start_min = (k % 2 == 1) ? 7'd0 : cfg_data_t'($urandom_range(2));
            start_sec = cfg_data_t'($urandom_range(127));
            bonus     = (k == 4) ? cfg_data_t'($urandom_range(127))
                                 : cfg_data_t'($urandom_range(3));
            if (k == 2)
            begin
                start_min = '0;
                start_sec = '0;
                bonus     = '0;
            end
            if (k == RandomPhases - 1)
            begin
                start_min = cfg_data_t'($urandom_range(127));
                start_sec = cfg_data_t'($urandom_range(127));
            end
            load_config(start_min, start_sec, bonus);
            send_word(CMD_INIT, 1'($urandom_range(1)));
            repeat (WordsPerPhase - 1)
            begin
                if ($urandom_range(59) == 0)
                    drain();
                send_word(pick_cmd(), 1'($urandom_range(1)));
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tcc_pkg.sv
rtl/tcc_in_if.sv
rtl/tcc_out_if.sv
rtl/two_player_countdown_clock_unit.sv
tb/tcc_display_check.sv
tb/two_player_countdown_clock_unit_test.sv
